// ===== hdl/segx_pkg.sv =====
package segx_pkg;

   // coordinate width of the ports
   localparam int COORD_WIDTH = 16;

   // coordinates are used as their low EFF_W bits, sign extended
   localparam int EFF_W   = (COORD_WIDTH > 19) ? 19 : COORD_WIDTH;
   localparam int DIFF_W  = EFF_W + 1;          // endpoint differences
   localparam int PROD_W  = 2 * EFF_W + 2;      // difference products
   localparam int CROSS_W = 2 * EFF_W + 3;      // cross products
   localparam int PDEN_W  = EFF_W + CROSS_W;    // p * den
   localparam int TR_W    = CROSS_W + DIFF_W;   // tnum * r
   localparam int NUM_W   = 3 * EFF_W + 5;      // point numerator
   localparam int DEN_W   = 2 * EFF_W + 2;      // |den|
   localparam int QUO_W   = EFF_W + 1;          // quotient bits before saturation

   localparam logic [1:0] REL_GENERAL   = 2'd0;
   localparam logic [1:0] REL_PARALLEL  = 2'd1;
   localparam logic [1:0] REL_COLLINEAR = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_start_x;
      logic signed [COORD_WIDTH-1:0] a_start_y;
      logic signed [COORD_WIDTH-1:0] a_end_x;
      logic signed [COORD_WIDTH-1:0] a_end_y;
      logic signed [COORD_WIDTH-1:0] b_start_x;
      logic signed [COORD_WIDTH-1:0] b_start_y;
      logic signed [COORD_WIDTH-1:0] b_end_x;
      logic signed [COORD_WIDTH-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic [1:0]                    relation;
      logic                          point_valid;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
   } rsp_type;

   // classification that travels beside the point division
   typedef struct packed {
      logic       hit;
      logic [1:0] relation;
      logic       point_valid;
   } side_type;

endpackage

// ===== hdl/segment_intersection_test_top.sv =====
// Segment intersection test. Each transfer on req_ carries two segments as
// four signed endpoints; each transfer on rsp_ returns hit, relation
// (general / parallel / collinear) and, for crossing lines, the line
// intersection point rounded half away from zero and saturated to the
// coordinate range (zero when point_valid is low). The block is a straight
// pipeline: one item may be accepted every cycle while rsp_ is not stalled,
// and results come back in order (EFF_W is the coordinate width capped at
// 19). The pipeline is six stages of cross-product arithmetic followed by
// the point divider, which resolves one quotient bit per stage. A stall on
// rsp_ while a result is offered freezes the whole pipeline and is reflected
// on req_stall in the same cycle.
module segment_intersection_test_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  segx_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output segx_pkg::rsp_type rsp_data
);

   localparam int DEPTH = segx_pkg::QUO_W + 2;   // divider register stages
   localparam int W     = segx_pkg::COORD_WIDTH;

   // whole pipeline advances unless a finished result is held off
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // front end: differences, cross products, classification, numerators
   logic                               f_valid;
   segx_pkg::side_type                 f_side;
   logic [segx_pkg::NUM_W-1:0]         f_nx_mag, f_ny_mag;
   logic                               f_nx_neg, f_ny_neg;
   logic [segx_pkg::DEN_W-1:0]         f_den;

   segx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_side  (f_side),
      .num_x_mag (f_nx_mag),
      .num_x_neg (f_nx_neg),
      .num_y_mag (f_ny_mag),
      .num_y_neg (f_ny_neg),
      .den_mag   (f_den)
   );

   // one divider lane per coordinate
   logic signed [segx_pkg::EFF_W-1:0] px_c, py_c;

   segx_div u_div_x (
      .clock   (clock),
      .enable  (advance),
      .num_mag (f_nx_mag),
      .num_neg (f_nx_neg),
      .den_mag (f_den),
      .coord   (px_c)
   );

   segx_div u_div_y (
      .clock   (clock),
      .enable  (advance),
      .num_mag (f_ny_mag),
      .num_neg (f_ny_neg),
      .den_mag (f_den),
      .coord   (py_c)
   );

   // valid and classification ride alongside the divider stages
   logic               v_ff    [0:DEPTH-1];
   segx_pkg::side_type side_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= f_valid;
         for (int i = 1; i < DEPTH; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= f_side;
         for (int i = 1; i < DEPTH; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // result assembly; point forced to zero when the lines do not cross
   always_comb begin
      rsp_data.hit         = side_ff[DEPTH-1].hit;
      rsp_data.relation    = side_ff[DEPTH-1].relation;
      rsp_data.point_valid = side_ff[DEPTH-1].point_valid;
      rsp_data.point_x     = side_ff[DEPTH-1].point_valid ? W'(px_c) : '0;
      rsp_data.point_y     = side_ff[DEPTH-1].point_valid ? W'(py_c) : '0;
   end

   assign rsp_valid = v_ff[DEPTH-1];

endmodule

// ===== hdl/segx_front.sv =====
module segx_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  segx_pkg::req_type                   in_data,
   output logic                                out_valid,
   output segx_pkg::side_type                  out_side,
   output logic [segx_pkg::NUM_W-1:0]          num_x_mag,
   output logic                                num_x_neg,
   output logic [segx_pkg::NUM_W-1:0]          num_y_mag,
   output logic                                num_y_neg,
   output logic [segx_pkg::DEN_W-1:0]          den_mag
);

   localparam int E  = segx_pkg::EFF_W;
   localparam int DW = segx_pkg::DIFF_W;
   localparam int PW = segx_pkg::PROD_W;
   localparam int CW = segx_pkg::CROSS_W;
   localparam int NW = segx_pkg::NUM_W;

   // true when the four sign bits are not all alike
   function automatic logic mixed4(input logic a, input logic b, input logic c,
                                   input logic d);
      mixed4 = !((a == b) && (a == c) && (a == d));
   endfunction

   // stage 0: trimmed coordinates, differences, collinear flags
   logic signed [E-1:0]  px, py, p2x, p2y, qx, qy, q2x, q2y;
   logic signed [DW-1:0] rx_in, ry_in, sx_in, sy_in, dx_in, dy_in;
   logic signed [DW-1:0] ex1, ex2, ex3, ey1, ey2, ey3;
   logic                 touch_in, mix_in;

   assign px  = $signed(in_data.a_start_x[E-1:0]);
   assign py  = $signed(in_data.a_start_y[E-1:0]);
   assign p2x = $signed(in_data.a_end_x[E-1:0]);
   assign p2y = $signed(in_data.a_end_y[E-1:0]);
   assign qx  = $signed(in_data.b_start_x[E-1:0]);
   assign qy  = $signed(in_data.b_start_y[E-1:0]);
   assign q2x = $signed(in_data.b_end_x[E-1:0]);
   assign q2y = $signed(in_data.b_end_y[E-1:0]);

   assign rx_in = DW'(p2x) - DW'(px);
   assign ry_in = DW'(p2y) - DW'(py);
   assign sx_in = DW'(q2x) - DW'(qx);
   assign sy_in = DW'(q2y) - DW'(qy);
   assign dx_in = DW'(qx) - DW'(px);
   assign dy_in = DW'(qy) - DW'(py);
   assign ex1   = DW'(qx) - DW'(p2x);
   assign ex2   = DW'(q2x) - DW'(px);
   assign ex3   = DW'(q2x) - DW'(p2x);
   assign ey1   = DW'(qy) - DW'(p2y);
   assign ey2   = DW'(q2y) - DW'(py);
   assign ey3   = DW'(q2y) - DW'(p2y);

   assign touch_in = (px == qx && py == qy) || (px == q2x && py == q2y) ||
                     (p2x == qx && p2y == qy) || (p2x == q2x && p2y == q2y);
   assign mix_in   = mixed4(dx_in[DW-1], ex1[DW-1], ex2[DW-1], ex3[DW-1]) ||
                     mixed4(dy_in[DW-1], ey1[DW-1], ey2[DW-1], ey3[DW-1]);

   // stage 1
   logic                 v1_ff;
   logic signed [E-1:0]  px1_ff, py1_ff;
   logic signed [DW-1:0] rx1_ff, ry1_ff, sx1_ff, sy1_ff, dx1_ff, dy1_ff;
   logic                 coll1_ff;

   // stage 2: products
   logic                 v2_ff;
   logic signed [PW-1:0] dxry2_ff, dyrx2_ff, rxsy2_ff, rysx2_ff, dxsy2_ff, dysx2_ff;
   logic signed [E-1:0]  px2_ff, py2_ff;
   logic signed [DW-1:0] rx2_ff, ry2_ff;
   logic                 coll2_ff;

   // stage 3: cross products
   logic                 v3_ff;
   logic signed [CW-1:0] unum3_ff, den3_ff, tnum3_ff;
   logic signed [E-1:0]  px3_ff, py3_ff;
   logic signed [DW-1:0] rx3_ff, ry3_ff;
   logic                 coll3_ff;

   // stage 4: classification and point products
   logic                                  v4_ff;
   segx_pkg::side_type                    side4_ff, side4_in;
   logic signed [segx_pkg::PDEN_W-1:0]    pxden4_ff, pyden4_ff;
   logic signed [segx_pkg::TR_W-1:0]      trx4_ff, try4_ff;
   logic                                  dneg4_ff;
   logic [segx_pkg::DEN_W-1:0]            dmag4_ff;
   logic signed [CW-1:0]                  dabs_in;
   logic                                  t_in_unit, u_in_unit;

   // stage 5: point numerators
   logic                        v5_ff;
   segx_pkg::side_type          side5_ff;
   logic signed [NW-1:0]        nx5_ff, ny5_ff;
   logic                        dneg5_ff;
   logic [segx_pkg::DEN_W-1:0]  dmag5_ff;

   // stage 6: magnitudes and signs
   logic                        v6_ff;
   segx_pkg::side_type          side6_ff;
   logic [NW-1:0]               nxm6_ff, nym6_ff;
   logic                        nxs6_ff, nys6_ff;
   logic [segx_pkg::DEN_W-1:0]  dmag6_ff;

   always_comb begin
      if (den3_ff > 0) begin
         t_in_unit = (tnum3_ff >= 0) && (tnum3_ff <= den3_ff);
         u_in_unit = (unum3_ff >= 0) && (unum3_ff <= den3_ff);
      end else begin
         t_in_unit = (tnum3_ff <= 0) && (tnum3_ff >= den3_ff);
         u_in_unit = (unum3_ff <= 0) && (unum3_ff >= den3_ff);
      end
      side4_in = '0;
      if (unum3_ff == 0 && den3_ff == 0) begin
         side4_in.relation = segx_pkg::REL_COLLINEAR;
         side4_in.hit      = coll3_ff;
      end else if (den3_ff == 0) begin
         side4_in.relation = segx_pkg::REL_PARALLEL;
      end else begin
         side4_in.relation    = segx_pkg::REL_GENERAL;
         side4_in.hit         = t_in_unit && u_in_unit;
         side4_in.point_valid = 1'b1;
      end
      dabs_in = den3_ff[CW-1] ? -den3_ff : den3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         px1_ff   <= px;
         py1_ff   <= py;
         rx1_ff   <= rx_in;
         ry1_ff   <= ry_in;
         sx1_ff   <= sx_in;
         sy1_ff   <= sy_in;
         dx1_ff   <= dx_in;
         dy1_ff   <= dy_in;
         coll1_ff <= touch_in || mix_in;

         dxry2_ff <= PW'(dx1_ff) * PW'(ry1_ff);
         dyrx2_ff <= PW'(dy1_ff) * PW'(rx1_ff);
         rxsy2_ff <= PW'(rx1_ff) * PW'(sy1_ff);
         rysx2_ff <= PW'(ry1_ff) * PW'(sx1_ff);
         dxsy2_ff <= PW'(dx1_ff) * PW'(sy1_ff);
         dysx2_ff <= PW'(dy1_ff) * PW'(sx1_ff);
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         rx2_ff   <= rx1_ff;
         ry2_ff   <= ry1_ff;
         coll2_ff <= coll1_ff;

         unum3_ff <= CW'(dxry2_ff) - CW'(dyrx2_ff);
         den3_ff  <= CW'(rxsy2_ff) - CW'(rysx2_ff);
         tnum3_ff <= CW'(dxsy2_ff) - CW'(dysx2_ff);
         px3_ff   <= px2_ff;
         py3_ff   <= py2_ff;
         rx3_ff   <= rx2_ff;
         ry3_ff   <= ry2_ff;
         coll3_ff <= coll2_ff;

         side4_ff  <= side4_in;
         pxden4_ff <= segx_pkg::PDEN_W'(px3_ff) * segx_pkg::PDEN_W'(den3_ff);
         pyden4_ff <= segx_pkg::PDEN_W'(py3_ff) * segx_pkg::PDEN_W'(den3_ff);
         trx4_ff   <= segx_pkg::TR_W'(tnum3_ff) * segx_pkg::TR_W'(rx3_ff);
         try4_ff   <= segx_pkg::TR_W'(tnum3_ff) * segx_pkg::TR_W'(ry3_ff);
         dneg4_ff  <= den3_ff[CW-1];
         dmag4_ff  <= dabs_in[segx_pkg::DEN_W-1:0];

         side5_ff <= side4_ff;
         nx5_ff   <= NW'(pxden4_ff) + NW'(trx4_ff);
         ny5_ff   <= NW'(pyden4_ff) + NW'(try4_ff);
         dneg5_ff <= dneg4_ff;
         dmag5_ff <= dmag4_ff;

         side6_ff <= side5_ff;
         nxm6_ff  <= nx5_ff[NW-1] ? NW'(-nx5_ff) : NW'(nx5_ff);
         nym6_ff  <= ny5_ff[NW-1] ? NW'(-ny5_ff) : NW'(ny5_ff);
         nxs6_ff  <= nx5_ff[NW-1] ^ dneg5_ff;
         nys6_ff  <= ny5_ff[NW-1] ^ dneg5_ff;
         dmag6_ff <= dmag5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign out_side  = side6_ff;
   assign num_x_mag = nxm6_ff;
   assign num_x_neg = nxs6_ff;
   assign num_y_mag = nym6_ff;
   assign num_y_neg = nys6_ff;
   assign den_mag   = dmag6_ff;

endmodule

// ===== hdl/segx_div.sv =====
module segx_div (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [segx_pkg::NUM_W-1:0]          num_mag,
   input  logic                                num_neg,
   input  logic [segx_pkg::DEN_W-1:0]          den_mag,
   output logic signed [segx_pkg::EFF_W-1:0]   coord
);

   localparam int NW = segx_pkg::NUM_W;
   localparam int DW = segx_pkg::DEN_W;
   localparam int QW = segx_pkg::QUO_W;
   localparam int E  = segx_pkg::EFF_W;

   localparam logic [E-1:0]  MIN_C   = {1'b1, {(E-1){1'b0}}};
   localparam logic [E-1:0]  MAX_C   = ~MIN_C;
   localparam logic [QW:0]   POS_LIM = (QW+1)'(MAX_C);
   localparam logic [QW:0]   NEG_LIM = (QW+1)'(MIN_C);

   logic [NW-1:0] rem_ff [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic [DW-1:0] d_ff   [0:QW];
   logic          neg_ff [0:QW];
   logic          ovf_ff [0:QW];

   logic [NW-1:0] dq_in;
   assign dq_in = NW'(den_mag) << QW;

   // quotient too large for QW bits: saturates regardless
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num_mag;
         q_ff[0]   <= '0;
         d_ff[0]   <= den_mag;
         neg_ff[0] <= num_neg;
         ovf_ff[0] <= num_mag >= dq_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < QW; i++) begin : g_step
      localparam int BIT = QW - 1 - i;
      logic [NW-1:0] trial_in;
      logic          fits_in;
      assign trial_in = NW'(d_ff[i]) << BIT;
      assign fits_in  = rem_ff[i] >= trial_in;
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i+1] <= fits_in ? rem_ff[i] - trial_in : rem_ff[i];
            q_ff[i+1]   <= q_ff[i] | (QW'(fits_in) << BIT);
            d_ff[i+1]   <= d_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   // round half away from zero, then saturate
   logic          up_in;
   logic [QW:0]   qr_in;
   logic [E-1:0]  coord_in;
   logic [E-1:0]  coord_ff;

   always_comb begin
      up_in = ((NW+1)'(rem_ff[QW]) << 1) >= (NW+1)'(d_ff[QW]);
      qr_in = (QW+1)'(q_ff[QW]) + (QW+1)'(up_in);
      if (neg_ff[QW]) begin
         if (ovf_ff[QW] || qr_in > NEG_LIM) coord_in = MIN_C;
         else                               coord_in = E'(~qr_in + 1'b1);
      end else begin
         if (ovf_ff[QW] || qr_in > POS_LIM) coord_in = MAX_C;
         else                               coord_in = E'(qr_in);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = $signed(coord_ff);

endmodule

// ===== tb/sv/tb_segment_intersection_test_top.sv =====
module tb_segment_intersection_test_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = segx_pkg::EFF_W + 8;
   localparam int CYCLE_CAP = 400000;
   localparam int N_RANDOM  = 1200;
   localparam int EW        = segx_pkg::EFF_W;
   localparam int CWD       = segx_pkg::COORD_WIDTH;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   segx_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   segx_pkg::rsp_type rsp_data;

   segx_pkg::req_type pending_segments[$];   // items waiting to be driven
   segx_pkg::rsp_type expected_crossings[$]; // predictions waiting for a result
   int      error_count = 0;
   int      cycle_count = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      hit_count = 0;
   int      rel_count[3] = '{0, 0, 0};
   bit      stimulus_done = 1'b0;

   segment_intersection_test_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // coordinate as the block sees it: low EFF_W bits, sign extended
   function automatic longint coord_value(input logic [CWD-1:0] raw);
      longint v;
      v = longint'(raw[EW-1:0]);
      if (raw[EW-1]) v = v - (longint'(1) << EW);
      return v;
   endfunction

   // nearest integer, halves away from zero, clamped; den > 0
   function automatic longint round_clamp(input longint num, input longint den);
      longint quo, rem, top, bottom;
      quo = num / den;
      rem = num % den;
      if (rem < 0) rem = -rem;
      top = (longint'(1) << (EW - 1)) - 1;
      bottom = -top - 1;
      if (2 * rem >= den) quo += (num < 0) ? -1 : 1;
      if (quo > top) quo = top;
      if (quo < bottom) quo = bottom;
      return quo;
   endfunction

   function automatic bit all_same_sign(input longint d0, d1, d2, d3);
      return ((d0 < 0) == (d1 < 0)) && ((d0 < 0) == (d2 < 0)) && ((d0 < 0) == (d3 < 0));
   endfunction

   function automatic bit within_unit(input longint num, input longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
   endfunction

   function automatic segx_pkg::rsp_type predict_crossing(input segx_pkg::req_type seg);
      segx_pkg::rsp_type res;
      longint px, py, p2x, p2y, qx, qy, q2x, q2y;
      longint rx, ry, sx, sy, dx, dy, unum, den, tnum, mag, nx, ny;
      bit shared;
      px  = coord_value(seg.a_start_x);  py  = coord_value(seg.a_start_y);
      p2x = coord_value(seg.a_end_x);    p2y = coord_value(seg.a_end_y);
      qx  = coord_value(seg.b_start_x);  qy  = coord_value(seg.b_start_y);
      q2x = coord_value(seg.b_end_x);    q2y = coord_value(seg.b_end_y);
      rx = p2x - px;  ry = p2y - py;
      sx = q2x - qx;  sy = q2y - qy;
      dx = qx - px;   dy = qy - py;
      unum = dx * ry - dy * rx;
      den  = rx * sy - ry * sx;
      tnum = dx * sy - dy * sx;
      res = '0;
      if (unum == 0 && den == 0) begin
         shared = (px == qx && py == qy) || (px == q2x && py == q2y) ||
                  (p2x == qx && p2y == qy) || (p2x == q2x && p2y == q2y);
         res.relation = segx_pkg::REL_COLLINEAR;
         res.hit = shared ||
                   !all_same_sign(qx - px, qx - p2x, q2x - px, q2x - p2x) ||
                   !all_same_sign(qy - py, qy - p2y, q2y - py, q2y - p2y);
      end else if (den == 0) begin
         res.relation = segx_pkg::REL_PARALLEL;
      end else begin
         res.relation = segx_pkg::REL_GENERAL;
         res.hit = within_unit(tnum, den) && within_unit(unum, den);
         res.point_valid = 1'b1;
         nx = px * den + tnum * rx;
         ny = py * den + tnum * ry;
         mag = den;
         if (den < 0) begin
            mag = -den;
            nx = -nx;
            ny = -ny;
         end
         res.point_x = CWD'(round_clamp(nx, mag));
         res.point_y = CWD'(round_clamp(ny, mag));
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("mismatch @%0d result %0d: %s got %0d expected %0d",
               cycle_count, checked_count, what, got, want);
   endtask

   task automatic add_segments(input longint ax, ay, bx, by, cx, cy, dx, dy);
      segx_pkg::req_type seg;
      seg.a_start_x = CWD'(ax);  seg.a_start_y = CWD'(ay);
      seg.a_end_x   = CWD'(bx);  seg.a_end_y   = CWD'(by);
      seg.b_start_x = CWD'(cx);  seg.b_start_y = CWD'(cy);
      seg.b_end_x   = CWD'(dx);  seg.b_end_y   = CWD'(dy);
      pending_segments.insert(pending_segments.size(), seg);
   endtask

   // random coordinate: mostly a small window so relations and hits vary,
   // sometimes full range to reach saturation and wide products
   function automatic longint pick_coord(input int spread);
      if (spread == 0) return longint'($urandom_range(0, 16)) - 8;
      if (spread == 1) return longint'($urandom_range(0, 400)) - 200;
      return longint'($signed(16'($urandom)));
   endfunction

   // driver: bursts with random gaps; valid holds while stalled
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      segx_pkg::req_type next_seg;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) sent_count <= sent_count + 1;
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_segments.size() > 0) begin
            next_seg = pending_segments.pop_front();
            req_valid <= 1'b1;
            req_data <= next_seg;
            expected_crossings.insert(expected_crossings.size(), predict_crossing(next_seg));
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern: alternates between quiet and busy stretches
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 300;
      if (reset || stall_phase < 100) rsp_stall <= 1'b0;
      else if (stall_phase < 200) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= ($urandom_range(0, 1) == 0);
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      segx_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_crossings.size() == 0) begin
            error_count++;
            $display("unexpected result @%0d", cycle_count);
         end else begin
            want = expected_crossings.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", rsp_data.hit, want.hit);
            if (rsp_data.relation !== want.relation)
               report_mismatch("relation", rsp_data.relation, want.relation);
            if (rsp_data.point_valid !== want.point_valid)
               report_mismatch("point_valid", rsp_data.point_valid, want.point_valid);
            if (rsp_data.point_x !== want.point_x)
               report_mismatch("point_x", rsp_data.point_x, want.point_x);
            if (rsp_data.point_y !== want.point_y)
               report_mismatch("point_y", rsp_data.point_y, want.point_y);
            if (want.hit) hit_count++;
            if (want.relation <= segx_pkg::REL_COLLINEAR) rel_count[want.relation]++;
            checked_count++;
         end
      end
   end

   initial begin
      longint ax, ay, bx, by, cx, cy, k;
      int spread, shape;
      // directed: crossing, touching, parallel, collinear overlap and gap,
      // degenerate points, extremes and saturation
      add_segments(0, 0, 10, 10, 0, 10, 10, 0);
      add_segments(0, 0, 10, 0, 10, 0, 10, 5);
      add_segments(0, 0, 10, 0, 0, 5, 10, 5);
      add_segments(0, 0, 10, 0, 5, 0, 20, 0);
      add_segments(0, 0, 10, 0, 11, 0, 20, 0);
      add_segments(0, 0, 0, 10, 0, 10, 0, 20);
      add_segments(0, 0, 0, 10, 0, -5, 0, -1);
      add_segments(3, 3, 3, 3, 3, 3, 3, 3);
      add_segments(3, 3, 3, 3, 4, 4, 4, 4);
      add_segments(0, 0, 10, 10, 5, 5, 5, 5);
      add_segments(0, 0, 4, 0, 1, 1, 2, 3);
      add_segments(0, 0, 3, 1, 1, 0, 0, 1);
      add_segments(0, 0, 1, 0, 0, 1, 1, 3);
      add_segments(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      add_segments(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
      add_segments(0, 0, 1, 1, 32767, 0, 32767, 1);
      add_segments(0, 0, -1, -1, -32768, 0, -32768, 1);
      add_segments(0, 0, 1, 32767, 1, 0, 2, -32768);
      add_segments(-32768, 0, 32767, 0, -32768, -1, 32767, 1);
      add_segments(0, -32768, 0, 32767, 0, -32768, 0, 32767);
      add_segments(-1, -1, -1, -1, -1, -1, 0, 0);
      add_segments(0, 0, 2, 1, 1, 0, 1, 1);
      add_segments(0, 0, 3, 0, 1, -1, 2, 2);
      for (int i = 0; i < N_RANDOM; i++) begin
         spread = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
         shape = $urandom_range(0, 9);
         ax = pick_coord(spread);  ay = pick_coord(spread);
         bx = pick_coord(spread);  by = pick_coord(spread);
         if (shape == 0) begin
            // collinear: both segments on one line through a
            k = longint'($urandom_range(0, 6)) - 3;
            cx = ax + k * (bx - ax);  cy = ay + k * (by - ay);
            k = longint'($urandom_range(0, 6)) - 3;
            add_segments(ax, ay, bx, by, cx, cy, ax + k * (bx - ax), ay + k * (by - ay));
         end else if (shape == 1) begin
            // parallel: same direction, shifted
            cx = pick_coord(spread);  cy = pick_coord(spread);
            add_segments(ax, ay, bx, by, cx, cy, cx + (bx - ax), cy + (by - ay));
         end else if (shape == 2) begin
            // shared endpoint
            add_segments(ax, ay, bx, by, bx, by, pick_coord(spread), pick_coord(spread));
         end else begin
            add_segments(ax, ay, bx, by, pick_coord(spread), pick_coord(spread),
                         pick_coord(spread), pick_coord(spread));
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_segments.size() == 0 && !req_valid);
      @(posedge clock);
      wait (expected_crossings.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
      $display("checked %0d segment pairs (%0d hits): %0d general, %0d parallel, %0d collinear",
               checked_count, hit_count, rel_count[0], rel_count[1], rel_count[2]);
      $display("directed extremes, saturated points and random bursts with stalls");
      if (error_count == 0 && expected_crossings.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_CAP);
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== segment_intersection_test_top.f =====
hdl/segx_pkg.sv
hdl/segx_front.sv
hdl/segx_div.sv
hdl/segment_intersection_test_top.sv
tb/sv/tb_segment_intersection_test_top.sv
